@@ hdl/cxpc_pkg.sv @@
`timescale 1ns / 1ps

package cxpc_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // One input word after unpacking from the stream
  typedef struct packed {
    op_e             operation;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] rand_key;
    logic            first_byte;
    logic            last_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic [ByteW-1:0] result_byte;
    logic            end_of_packet;
    logic            checksum_ok;
  } res_t;

endpackage

@@ hdl/chained_xor_packet_codec_unit.sv @@
`timescale 1ns / 1ps

// Byte-serial packet codec with two chained XOR layers and a sum checksum.
// Slave stream: one word per byte of the protected region, checksum byte
// first. tdata carries data_byte and rand_key, tuser the operation (encode
// or decode) and the packet-start flag, tlast the final byte of the packet.
// Master stream: one word per input word, in order. tdata is the coded byte,
// tlast copies the input tlast, tuser is the checksum result, set only on
// the last byte of a decoded packet whose payload sum matches.
// The user must load the fixed key through cfg_we_i/cfg_wdata_i only while
// the block is idle; the block itself does not enforce this. A word is taken
// into the input register, then the chain logic loads the output register,
// which drives the master stream. Throughput is one word per cycle while the
// receiver does not stall; the single 8-bit add-and-XOR chain update sets it.
// Reset empties both registers and clears the chain state and the key.
// When the receiver stalls, the output register holds its word and the input
// register fills; tready drops only when both are occupied.
module chained_xor_packet_codec_unit import cxpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [7:0] data_byte, [15:8] rand_key
  input  logic [1:0]       s_axis_tuser,   // [0] operation, [1] first_byte
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] result_byte
  output logic             m_axis_tuser,   // [0] checksum_ok
  output logic             m_axis_tlast
);

  logic [ByteW-1:0] fixed_key_q;
  logic             in_valid_q, in_valid_d;
  item_t            in_word_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_word_q;
  res_t             res;
  logic             out_free, advance, accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_key_q <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fixed_key_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q.operation  <= op_e'(s_axis_tuser[0]);
      in_word_q.data_byte  <= s_axis_tdata[7:0];
      in_word_q.rand_key   <= s_axis_tdata[15:8];
      in_word_q.first_byte <= s_axis_tuser[1];
      in_word_q.last_byte  <= s_axis_tlast;
    end
    if (advance) begin
      out_word_q <= res;
    end
  end

  cxpc_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (in_word_q),
    .fixed_key_i (fixed_key_q),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q.result_byte;
  assign m_axis_tuser  = out_word_q.checksum_ok;
  assign m_axis_tlast  = out_word_q.end_of_packet;

endmodule

@@ hdl/cxpc_chain.sv @@
`timescale 1ns / 1ps

module cxpc_chain import cxpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  item_t            item_i,
  input  logic [ByteW-1:0] fixed_key_i,
  output res_t             res_o
);

  logic [ByteW-1:0] prev_plain_q,  prev_plain_d;
  logic [ByteW-1:0] prev_cipher_q, prev_cipher_d;
  logic [ByteW-1:0] position_q,    position_d;
  logic [ByteW-1:0] packet_key_q,  packet_key_d;
  logic [ByteW-1:0] expected_q,    expected_d;
  logic [ByteW-1:0] sum_q,         sum_d;

  logic [ByteW-1:0] pp, pc, pos, key, sum_cur;
  logic [ByteW-1:0] step, plain_mix, cipher_mix;
  logic [ByteW-1:0] plain, inner, cipher;

  always_comb begin
    // packet start clears the chains before this word is processed
    pp      = item_i.first_byte ? '0 : prev_plain_q;
    pc      = item_i.first_byte ? '0 : prev_cipher_q;
    pos     = item_i.first_byte ? '0 : position_q;
    sum_cur = item_i.first_byte ? '0 : sum_q;
    key     = item_i.first_byte ? item_i.rand_key : packet_key_q;

    step       = pos + ByteW'(1);
    plain_mix  = pp + key + step;
    cipher_mix = pc + fixed_key_i + step;

    unique case (item_i.operation)
      OP_ENCODE: begin
        plain  = item_i.data_byte;
        inner  = plain ^ plain_mix;
        cipher = inner ^ cipher_mix;
      end
      OP_DECODE: begin
        cipher = item_i.data_byte;
        inner  = cipher ^ cipher_mix;
        plain  = inner ^ plain_mix;
      end
      default: begin
        plain  = item_i.data_byte;
        inner  = plain ^ plain_mix;
        cipher = inner ^ cipher_mix;
      end
    endcase

    // checksum byte is latched, later plain bytes are summed
    if (item_i.first_byte) begin
      expected_d = plain;
      sum_d      = sum_cur;
    end else begin
      expected_d = expected_q;
      sum_d      = sum_cur + plain;
    end

    prev_plain_d  = inner;
    prev_cipher_d = cipher;
    position_d    = pos + ByteW'(1);
    packet_key_d  = key;

    res_o.result_byte   = (item_i.operation == OP_DECODE) ? plain : cipher;
    res_o.end_of_packet = item_i.last_byte;
    res_o.checksum_ok   = item_i.last_byte && (item_i.operation == OP_DECODE) &&
                          (sum_d == expected_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_plain_q  <= '0;
      prev_cipher_q <= '0;
      position_q    <= '0;
      packet_key_q  <= '0;
      expected_q    <= '0;
      sum_q         <= '0;
    end else if (advance_i) begin
      prev_plain_q  <= prev_plain_d;
      prev_cipher_q <= prev_cipher_d;
      position_q    <= position_d;
      packet_key_q  <= packet_key_d;
      expected_q    <= expected_d;
      sum_q         <= sum_d;
    end
  end

endmodule
